[rtl/utxdt_pkg.sv]
// ----------------------------------------------------------------------------
// utxdt_pkg
// Shared types and constants for the UART transmitter with delay timer.
// ----------------------------------------------------------------------------
package utxdt_pkg;

  localparam int DATA_BITS_DEF   = 8;
  localparam int DELAY_WIDTH_DEF = 32;
  localparam int DATA_BYTE_W     = 8;
  localparam int DELAY_TICKS_W   = 32;
  localparam int BITS_LEFT_W     = 4;

  typedef enum logic [1:0] {
    CMD_TICK  = 2'd0,
    CMD_SEND  = 2'd1,
    CMD_DELAY = 2'd2,
    CMD_RSVD  = 2'd3
  } cmd_t;

  typedef struct packed {
    logic tx_line;
    logic ready_res;
    logic accepted;
  } res_t;

endpackage

[rtl/utxdt_in_if.sv]
// ----------------------------------------------------------------------------
// utxdt_in_if
// Input channel: one tick or command per transaction.
// ----------------------------------------------------------------------------
interface utxdt_in_if
  import utxdt_pkg::*;
();
  logic                     valid;
  logic                     ready;
  logic [1:0]               command;
  logic [DATA_BYTE_W-1:0]   data_byte;
  logic [DELAY_TICKS_W-1:0] delay_ticks;

  modport source (output valid, output command, output data_byte, output delay_ticks,
                  input ready);
  modport sink   (input valid, input command, input data_byte, input delay_ticks,
                  output ready);
endinterface

[rtl/utxdt_out_if.sv]
// ----------------------------------------------------------------------------
// utxdt_out_if
// Result channel: line level and status after each input transaction.
// ----------------------------------------------------------------------------
interface utxdt_out_if;
  logic valid;
  logic ready;
  logic tx_line;
  logic ready_res;
  logic accepted;

  modport source (output valid, output tx_line, output ready_res, output accepted,
                  input ready);
  modport sink   (input valid, input tx_line, input ready_res, input accepted,
                  output ready);
endinterface

[rtl/uart_tx_with_delay_timer_unit.sv]
// ----------------------------------------------------------------------------
// uart_tx_with_delay_timer_unit
// Bit-timed 8N1 UART transmitter with a busy delay timer.
// ----------------------------------------------------------------------------
// Each input transaction is a bit tick, a send-byte or a start-delay command
// and yields exactly one result transaction: the line level, the ready flag
// and whether the command was taken. Throughput is one transaction per clock
// while the result channel keeps taking results. An accepted transaction is
// held in the input register; once the result register is free, the state
// update is applied and its result loaded into the result register. A busy
// command is refused, never stalled. A delay of zero lasts 2^DELAY_WIDTH
// ticks.
module uart_tx_with_delay_timer_unit
  import utxdt_pkg::*;
#(
  parameter int DATA_BITS   = DATA_BITS_DEF,
  parameter int DELAY_WIDTH = DELAY_WIDTH_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  utxdt_in_if.sink     in_ch,
  utxdt_out_if.source  out_ch
);

  logic                     s1_valid_r;
  cmd_t                     s1_cmd_r;
  logic [DATA_BYTE_W-1:0]   s1_data_r;
  logic [DELAY_TICKS_W-1:0] s1_delay_r;
  logic                     out_valid_r;
  res_t                     res_r;
  res_t                     res;
  logic                     adv;

  // advance the staged transaction when the result register is free
  assign adv         = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !s1_valid_r || adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      s1_cmd_r   <= cmd_t'(in_ch.command);
      s1_data_r  <= in_ch.data_byte;
      s1_delay_r <= in_ch.delay_ticks;
    end
  end

  utxdt_engine #(
    .DATA_BITS   (DATA_BITS),
    .DELAY_WIDTH (DELAY_WIDTH)
  ) u_engine (
    .clk         (clk),
    .rst_n       (rst_n),
    .en          (adv),
    .cmd         (s1_cmd_r),
    .data_byte   (s1_data_r),
    .delay_ticks (s1_delay_r),
    .res         (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      res_r <= res;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.tx_line   = res_r.tx_line;
  assign out_ch.ready_res = res_r.ready_res;
  assign out_ch.accepted  = res_r.accepted;

endmodule

[rtl/utxdt_engine.sv]
// ----------------------------------------------------------------------------
// utxdt_engine
// Frame sequencer and delay counter; updates state once per enabled item.
// ----------------------------------------------------------------------------
module utxdt_engine
  import utxdt_pkg::*;
#(
  parameter int DATA_BITS   = DATA_BITS_DEF,
  parameter int DELAY_WIDTH = DELAY_WIDTH_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     en,
  input  cmd_t                     cmd,
  input  logic [DATA_BYTE_W-1:0]   data_byte,
  input  logic [DELAY_TICKS_W-1:0] delay_ticks,
  output res_t                     res
);

  typedef enum logic [5:0] {
    PH_IDLE  = 6'b000001,
    PH_START = 6'b000010,
    PH_DATA  = 6'b000100,
    PH_STOP  = 6'b001000,
    PH_DONE  = 6'b010000,
    PH_DELAY = 6'b100000
  } phase_t;

  localparam logic [BITS_LEFT_W-1:0] DataBitsCnt = BITS_LEFT_W'(DATA_BITS);

  phase_t                  phase_r, phase_nxt;
  logic [DATA_BITS-1:0]    shift_r, shift_nxt;
  logic [BITS_LEFT_W-1:0]  bits_r, bits_nxt, bits_dec;
  logic [DELAY_WIDTH-1:0]  delay_r, delay_nxt, delay_dec;
  logic                    ready_r, ready_nxt;
  logic                    line_r, line_nxt;
  logic                    acc;
  logic [15:0]             byte_ext;

  assign byte_ext  = 16'(data_byte);
  assign bits_dec  = bits_r - BITS_LEFT_W'(1);
  assign delay_dec = delay_r - DELAY_WIDTH'(1);

  always_comb begin
    phase_nxt = phase_r;
    shift_nxt = shift_r;
    bits_nxt  = bits_r;
    delay_nxt = delay_r;
    ready_nxt = ready_r;
    line_nxt  = line_r;
    acc       = 1'b0;
    case (cmd)
      CMD_TICK: begin
        case (phase_r)
          PH_START: begin
            line_nxt  = 1'b0;
            bits_nxt  = DataBitsCnt;
            phase_nxt = PH_DATA;
          end
          PH_DATA: begin
            line_nxt  = shift_r[0];
            shift_nxt = shift_r >> 1;
            bits_nxt  = bits_dec;
            if (bits_dec == '0) begin
              phase_nxt = PH_STOP;
            end
          end
          PH_STOP: begin
            line_nxt  = 1'b1;
            phase_nxt = PH_DONE;
          end
          PH_DONE: begin
            ready_nxt = 1'b1;
            phase_nxt = PH_IDLE;
          end
          PH_DELAY: begin
            // zero delay wraps here and runs the full counter range
            delay_nxt = delay_dec;
            if (delay_dec == '0) begin
              ready_nxt = 1'b1;
              phase_nxt = PH_IDLE;
            end
          end
          default: ;
        endcase
      end
      CMD_SEND: begin
        if (ready_r) begin
          shift_nxt = byte_ext[DATA_BITS-1:0];
          ready_nxt = 1'b0;
          phase_nxt = PH_START;
          acc       = 1'b1;
        end
      end
      CMD_DELAY: begin
        if (ready_r) begin
          delay_nxt = delay_ticks[DELAY_WIDTH-1:0];
          ready_nxt = 1'b0;
          phase_nxt = PH_DELAY;
          acc       = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      shift_r <= '0;
      bits_r  <= '0;
      delay_r <= '0;
      ready_r <= 1'b1;
      line_r  <= 1'b1;
    end else if (en) begin
      phase_r <= phase_nxt;
      shift_r <= shift_nxt;
      bits_r  <= bits_nxt;
      delay_r <= delay_nxt;
      ready_r <= ready_nxt;
      line_r  <= line_nxt;
    end
  end

  assign res.tx_line   = line_nxt;
  assign res.ready_res = ready_nxt;
  assign res.accepted  = acc;

endmodule
